FILE: rtl/core/tlrb_pkg.sv
// Types, sizes and codes for the terminal line read-ahead buffer.
// Depends on nothing; used by terminal_line_readahead_buffer_top.
`timescale 1ns / 1ps

package tlrb_pkg;

    // Block sizes
    localparam int UNITS       = 4;
    localparam int LINES       = 8;
    localparam int LINE_LENGTH = 64;

    // Derived widths
    localparam int UIDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int SLOT_W = $clog2(LINES);
    localparam int POS_W  = $clog2(LINE_LENGTH);
    localparam int LEN_W  = $clog2(LINE_LENGTH + 1);
    localparam int CNT_W  = $clog2(LINES + 1);

    localparam int LEN_AW     = UIDX_W + SLOT_W;
    localparam int CHAR_AW    = LEN_AW + POS_W;
    localparam int LEN_DEPTH  = 1 << LEN_AW;
    localparam int CHAR_DEPTH = 1 << CHAR_AW;

    // Command and status codes
    localparam logic       CMD_STORE  = 1'b0;
    localparam logic       CMD_READ   = 1'b1;
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_EMPTY   = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    typedef struct packed {
        logic       command;
        logic [2:0] unit;
        logic [7:0] rx_char;
        logic [6:0] read_size;
    } request_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [5:0] char_index;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STORE,
        S_RD_LEN,
        S_RD_CHARS
    } state_t;

    // Ring slot advance, wraps at LINES
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(LINES - 1))
            r = '0;
        else
            r = s + 1'b1;
        return r;
    endfunction

endpackage

FILE: rtl/core/terminal_line_readahead_buffer_top.sv
// Terminal line read-ahead buffer: line assembly, slot ring and line readout.
// Depends on tlrb_pkg (types, sizes, codes).
`timescale 1ns / 1ps

// Per-terminal line buffer. A command item is taken on a clock edge with start high
// and busy low. A store (command 0) appends rx_char to the line being built for its
// unit; a newline or a full line closes it into the ring of line slots. Stores
// produce no result; a store to a bad unit, or while every slot holds an unread
// line, is dropped. Stores sustain one item per clock while busy is low: the line
// length is read from the length RAM on the accept edge and written back on the
// next edge, and a following store to the same slot gets the new length by
// forwarding. A read (command 1) returns the oldest closed line, one result per
// character cut to read_size, with last set on the final one. A bad unit or zero
// size gives one result with status 2, an empty ring one result with status 1;
// these appear on the cycle after acceptance and do not raise busy. A line read
// keeps busy high for one length-RAM lookup, then one character-RAM read per
// result; results come on consecutive cycles, the first after S_RD_LEN, S_RD_CHARS
// and the registered character read. Results are shown for exactly one cycle with
// strobe high; the receiver cannot stall them, so it must take every strobe. Line
// lengths have reset-cleared valid bits, so no clearing pass runs after reset.

module terminal_line_readahead_buffer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tlrb_pkg::request_t request,
    output logic               busy,
    output logic               strobe,
    output tlrb_pkg::result_t  result
);

    localparam int UIDX_W    = tlrb_pkg::UIDX_W;
    localparam int SLOT_W    = tlrb_pkg::SLOT_W;
    localparam int POS_W     = tlrb_pkg::POS_W;
    localparam int LEN_W     = tlrb_pkg::LEN_W;
    localparam int CNT_W     = tlrb_pkg::CNT_W;
    localparam int LEN_AW    = tlrb_pkg::LEN_AW;

    // ---------------------------------------------------------------- state
    tlrb_pkg::state_t state_reg, state_next;

    // per-unit ring pointers and closed-line counts
    logic [SLOT_W-1:0] rdslot_reg  [tlrb_pkg::UNITS];
    logic [SLOT_W-1:0] wrslot_reg  [tlrb_pkg::UNITS];
    logic [CNT_W-1:0]  cnt_reg     [tlrb_pkg::UNITS];
    logic [SLOT_W-1:0] rdslot_next [tlrb_pkg::UNITS];
    logic [SLOT_W-1:0] wrslot_next [tlrb_pkg::UNITS];
    logic [CNT_W-1:0]  cnt_next    [tlrb_pkg::UNITS];

    // memories
    logic [LEN_W-1:0]            len_mem  [tlrb_pkg::LEN_DEPTH];
    logic [7:0]                  char_mem [tlrb_pkg::CHAR_DEPTH];
    logic [tlrb_pkg::LEN_DEPTH-1:0] len_vld_reg;

    // length read port and forwarding
    logic [LEN_W-1:0]  len_q_reg;
    logic              len_vld_q_reg;
    logic              len_fwd_reg;
    logic [LEN_W-1:0]  len_fwd_data_reg;
    logic [LEN_W-1:0]  len_eff;

    // captured item
    logic [UIDX_W-1:0] unit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [7:0]        char_reg;
    logic [6:0]        size_reg;

    // readout
    logic [POS_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  n_reg;
    logic [7:0]        char_q_reg;
    logic              rd_pend_reg;
    logic [POS_W-1:0]  rd_idx_q_reg;
    logic              rd_last_q_reg;
    logic              stat_pend_reg;
    logic [1:0]        stat_code_reg;

    // ------------------------------------------------------------- decode
    logic              acc;
    logic              u_ok;
    logic [UIDX_W-1:0] u_sel;
    logic              store_go;
    logic              read_go;
    logic              stat_go;
    logic [1:0]        stat_code;

    logic              len_rd_en;
    logic [LEN_AW-1:0] len_rd_addr;
    logic              len_we;
    logic [LEN_AW-1:0] len_wr_addr;
    logic [LEN_W-1:0]  len_wr_data;

    logic [LEN_W-1:0]  st_len;
    logic [LEN_W-1:0]  st_new_len;
    logic              st_close;

    logic [LEN_W-1:0]  rl_n;
    logic              rc_last;

    assign busy = (state_reg == tlrb_pkg::S_RD_LEN) || (state_reg == tlrb_pkg::S_RD_CHARS);
    assign acc  = start && !busy;

    assign len_eff = len_fwd_reg   ? len_fwd_data_reg :
                     len_vld_q_reg ? len_q_reg : '0;

    // store arithmetic (state S_STORE)
    always_comb
    begin
        if (len_eff >= LEN_W'(tlrb_pkg::LINE_LENGTH))
            st_len = LEN_W'(tlrb_pkg::LINE_LENGTH - 1);
        else
            st_len = len_eff;
        st_new_len = st_len + 1'b1;
        st_close   = (st_new_len == LEN_W'(tlrb_pkg::LINE_LENGTH)) ||
                     (char_reg == tlrb_pkg::NEWLINE_CHAR);
    end

    // read arithmetic
    assign rl_n    = (LEN_W'(size_reg) < len_eff) ? LEN_W'(size_reg) : len_eff;
    assign rc_last = (LEN_W'(idx_reg) + 1'b1) == n_reg;

    // pointer updates of the item in flight, seen by the next accept
    always_comb
    begin
        for (int u = 0; u < tlrb_pkg::UNITS; u++)
        begin
            rdslot_next[u] = rdslot_reg[u];
            wrslot_next[u] = wrslot_reg[u];
            cnt_next[u]    = cnt_reg[u];
        end
        if (state_reg == tlrb_pkg::S_STORE && st_close)
        begin
            wrslot_next[unit_reg] = tlrb_pkg::slot_inc(slot_reg);
            cnt_next[unit_reg]    = cnt_reg[unit_reg] + 1'b1;
        end
        else if (state_reg == tlrb_pkg::S_RD_LEN)
        begin
            rdslot_next[unit_reg] = tlrb_pkg::slot_inc(slot_reg);
            cnt_next[unit_reg]    = cnt_reg[unit_reg] - 1'b1;
        end
    end

    // accept decode
    always_comb
    begin
        u_ok      = {1'b0, request.unit} < 4'(tlrb_pkg::UNITS);
        u_sel     = u_ok ? request.unit[UIDX_W-1:0] : '0;
        store_go  = 1'b0;
        read_go   = 1'b0;
        stat_go   = 1'b0;
        stat_code = tlrb_pkg::STS_EMPTY;
        if (acc)
        begin
            if (request.command == tlrb_pkg::CMD_STORE)
            begin
                store_go = u_ok && (cnt_next[u_sel] < CNT_W'(tlrb_pkg::LINES));
            end
            else if (!u_ok || request.read_size == '0)
            begin
                stat_go   = 1'b1;
                stat_code = tlrb_pkg::STS_INVALID;
            end
            else if (cnt_next[u_sel] == '0)
            begin
                stat_go   = 1'b1;
                stat_code = tlrb_pkg::STS_EMPTY;
            end
            else
            begin
                read_go = 1'b1;
            end
        end
        if (state_reg == tlrb_pkg::S_RD_LEN && rl_n == '0)
        begin
            stat_go   = 1'b1;
            stat_code = tlrb_pkg::STS_EMPTY;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            tlrb_pkg::S_IDLE,
            tlrb_pkg::S_STORE:
            begin
                if (store_go)
                    state_next = tlrb_pkg::S_STORE;
                else if (read_go)
                    state_next = tlrb_pkg::S_RD_LEN;
                else
                    state_next = tlrb_pkg::S_IDLE;
            end
            tlrb_pkg::S_RD_LEN:
            begin
                if (rl_n == '0)
                    state_next = tlrb_pkg::S_IDLE;
                else
                    state_next = tlrb_pkg::S_RD_CHARS;
            end
            tlrb_pkg::S_RD_CHARS:
            begin
                if (rc_last)
                    state_next = tlrb_pkg::S_IDLE;
            end
            default: state_next = tlrb_pkg::S_IDLE;
        endcase
    end

    // memory port controls
    always_comb
    begin
        len_rd_en   = store_go || read_go;
        len_rd_addr = store_go ? {u_sel, wrslot_next[u_sel]} : {u_sel, rdslot_next[u_sel]};
        len_we      = 1'b0;
        len_wr_addr = {unit_reg, slot_reg};
        len_wr_data = '0;
        unique case (state_reg)
            tlrb_pkg::S_STORE:
            begin
                len_we      = 1'b1;
                len_wr_data = st_new_len;
            end
            tlrb_pkg::S_RD_LEN:
            begin
                len_we      = 1'b1;
                len_wr_data = '0;
            end
            default:
            begin
                len_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------ control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlrb_pkg::S_IDLE;
            len_vld_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            stat_pend_reg <= 1'b0;
            for (int u = 0; u < tlrb_pkg::UNITS; u++)
            begin
                rdslot_reg[u] <= '0;
                wrslot_reg[u] <= '0;
                cnt_reg[u]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= (state_reg == tlrb_pkg::S_RD_CHARS);
            stat_pend_reg <= stat_go;
            if (len_we)
                len_vld_reg[len_wr_addr] <= 1'b1;
            for (int u = 0; u < tlrb_pkg::UNITS; u++)
            begin
                rdslot_reg[u] <= rdslot_next[u];
                wrslot_reg[u] <= wrslot_next[u];
                cnt_reg[u]    <= cnt_next[u];
            end
        end
    end

    // ------------------------------------------------------------ payload regs
    always_ff @(posedge clk)
    begin
        if (store_go || read_go)
        begin
            unit_reg <= u_sel;
            slot_reg <= store_go ? wrslot_next[u_sel] : rdslot_next[u_sel];
            char_reg <= request.rx_char;
            size_reg <= request.read_size;
        end
        if (stat_go)
            stat_code_reg <= stat_code;
        if (state_reg == tlrb_pkg::S_RD_LEN)
        begin
            idx_reg <= '0;
            n_reg   <= rl_n;
        end
        else if (state_reg == tlrb_pkg::S_RD_CHARS)
        begin
            idx_reg       <= idx_reg + 1'b1;
            rd_idx_q_reg  <= idx_reg;
            rd_last_q_reg <= rc_last;
        end
    end

    // length RAM, one write and one registered read, same-edge write forwarded
    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_wr_addr] <= len_wr_data;
        if (len_rd_en)
        begin
            len_q_reg        <= len_mem[len_rd_addr];
            len_vld_q_reg    <= len_vld_reg[len_rd_addr];
            len_fwd_reg      <= len_we && (len_wr_addr == len_rd_addr);
            len_fwd_data_reg <= len_wr_data;
        end
    end

    // character RAM
    always_ff @(posedge clk)
    begin
        if (state_reg == tlrb_pkg::S_STORE)
            char_mem[{unit_reg, slot_reg, st_len[POS_W-1:0]}] <= char_reg;
        if (state_reg == tlrb_pkg::S_RD_CHARS)
            char_q_reg <= char_mem[{unit_reg, slot_reg, idx_reg}];
    end

    // ------------------------------------------------------------- results
    always_comb
    begin
        strobe = rd_pend_reg || stat_pend_reg;
        if (rd_pend_reg)
        begin
            result.out_char   = char_q_reg;
            result.char_index = 6'(rd_idx_q_reg);
            result.status     = tlrb_pkg::STS_OK;
            result.last       = rd_last_q_reg;
        end
        else
        begin
            result.out_char   = '0;
            result.char_index = '0;
            result.status     = stat_code_reg;
            result.last       = 1'b1;
        end
    end

    // ------------------------------------------------------------ assertions
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_pend_reg && stat_pend_reg))
        else $error("character and status result in the same cycle");

    a_line_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_pend_reg && !rd_last_q_reg) |=> rd_pend_reg)
        else $error("gap inside a line readout");

    a_read_has_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlrb_pkg::S_RD_LEN) |-> (cnt_reg[unit_reg] != '0))
        else $error("line read with no closed line");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlrb_pkg::S_STORE) |-> (cnt_reg[unit_reg] < CNT_W'(tlrb_pkg::LINES)))
        else $error("store into a full ring");

    a_chars_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlrb_pkg::S_RD_CHARS) |-> !stat_pend_reg)
        else $error("status result during line readout");

endmodule
